@@ rtl/core/mbrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrc_pkg: shared types and constants for the Modbus RTU response checker
// Item layouts, status codes, function codes, register map and CRC-16 step.
// ----------------------------------------------------------------------------
package mbrc_pkg;

	// received byte item
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} mbrc_rx_item_t;

	// result item
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  exception_code;
		logic        has_register;
		logic [4:0]  register_index;
		logic [15:0] register_value;
		logic        last;
	} mbrc_res_item_t;

	// status codes
	localparam logic [2:0] STATUS_OK          = 3'd0;
	localparam logic [2:0] STATUS_ID_MISMATCH = 3'd1;
	localparam logic [2:0] STATUS_CRC_ERROR   = 3'd2;
	localparam logic [2:0] STATUS_EXCEPTION   = 3'd3;
	localparam logic [2:0] STATUS_FC_MISMATCH = 3'd4;
	localparam logic [2:0] STATUS_BAD_COUNT   = 3'd5;
	localparam logic [2:0] STATUS_BAD_ECHO    = 3'd6;

	// function codes
	localparam logic [7:0] FC_COIL_STATUS   = 8'd1;
	localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FC_READ_INPUT    = 8'd4;
	localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
	localparam logic [7:0] FC_EXCEPTION_BIT = 8'h80;

	// register map (word index)
	localparam int          REG_ADDR_W           = 5;
	localparam logic [2:0]  REG_EXPECTED_SLAVE   = 3'd0;
	localparam logic [2:0]  REG_EXPECTED_FC      = 3'd1;
	localparam logic [2:0]  REG_REGISTER_COUNT   = 3'd2;
	localparam logic [2:0]  REG_FRAME_LENGTH     = 3'd3;
	localparam logic [2:0]  REG_ECHO_ADDRESS     = 3'd4;
	localparam logic [2:0]  REG_ECHO_VALUE       = 3'd5;

	// crc-16/modbus
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// one byte of reflected crc, bit at a time
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/modbus_rtu_response_checker_unit.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit: Modbus RTU response checker
// Runs CRC-16 over a response byte stream, keeps header and register words,
// checks the frame after its last CRC byte and emits a status or registers.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  rx      | in        | rx_valid/rx_stall  | rx_item  (byte, frame start)
//  res     | out       | res_valid/res_stall| res_item (status or register)
//  cfg     | in        | apb psel/penable   | paddr/pwdata, prdata back
//
//  One byte a cycle while rx is not stalled; a status result is loaded into
//  the output register at the edge that takes the last CRC byte.
//  A read reply emits its registers one at a time, each by a memory read
//  and then an output load; rx is stalled until the last register is loaded.
//  Reset opens a frame; the register memory is not cleared.
//  rx is also stalled while a result sits in the output register and res is
//  stalled.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_unit #(
	parameter int MAX_REGISTERS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// byte channel
	input  logic                     rx_valid,
	output logic                     rx_stall,
	input  mbrc_pkg::mbrc_rx_item_t  rx_item,
	// result channel
	output logic                     res_valid,
	input  logic                     res_stall,
	output mbrc_pkg::mbrc_res_item_t res_item,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [mbrc_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	import mbrc_pkg::*;

	localparam int AW         = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
	localparam int EMIT_LIMIT = (MAX_REGISTERS < 32) ? MAX_REGISTERS : 32;

	typedef enum logic [1:0] {
		SEQ_RUN,
		SEQ_READ,
		SEQ_LOAD
	} seq_state_t;

	// configuration registers
	logic [7:0]  expected_slave_id_q;
	logic [7:0]  expected_function_code_q;
	logic [5:0]  register_count_q;
	logic [6:0]  frame_length_q;
	logic [15:0] echo_address_q;
	logic [15:0] echo_value_q;

	// frame state
	logic [7:0]  byte_position_q;
	logic [15:0] crc_accumulator_q;
	logic [7:0]  received_slave_id_q;
	logic [7:0]  received_function_q;
	logic [7:0]  received_byte_count_q;
	logic [7:0]  received_crc_low_q;
	logic        echo_matches_q;
	logic [7:0]  high_byte_hold_q;
	logic        frame_open_q;

	// register memory
	logic [15:0] register_store [MAX_REGISTERS];
	logic [15:0] rd_data_q;

	// sequencer
	seq_state_t     seq_q;
	logic [4:0]     reg_idx_q;
	logic           res_valid_q;
	mbrc_res_item_t res_item_q;

	logic        rx_take;
	logic        cfg_write;
	logic [2:0]  cfg_idx;
	logic [7:0]  b;
	logic [7:0]  pos;
	logic        open_eff;
	logic [15:0] crc_eff;
	logic        echo_eff;
	logic [7:0]  end_pos;
	logic        in_frame;
	logic        at_end;
	logic [7:0]  sid_n;
	logic [7:0]  fc_n;
	logic [7:0]  bc_n;
	logic        echo_n;
	logic [7:0]  pos_m4;
	logic [6:0]  word_idx;
	logic        mem_we;
	logic        crc_ok;
	logic [5:0]  emit_n;
	logic [2:0]  fin_status;
	logic        fin_regs;
	logic        slot_free;
	logic        mem_re;

	// handshakes
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign cfg_idx   = paddr[REG_ADDR_W-1:2];
	assign slot_free = !res_valid_q || !res_stall;
	assign rx_stall  = (seq_q != SEQ_RUN) || !slot_free;
	assign rx_take   = rx_valid && !rx_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// register read back
	always_comb begin
		case (cfg_idx)
			REG_EXPECTED_SLAVE: prdata = {24'd0, expected_slave_id_q};
			REG_EXPECTED_FC:    prdata = {24'd0, expected_function_code_q};
			REG_REGISTER_COUNT: prdata = {26'd0, register_count_q};
			REG_FRAME_LENGTH:   prdata = {25'd0, frame_length_q};
			REG_ECHO_ADDRESS:   prdata = {16'd0, echo_address_q};
			REG_ECHO_VALUE:     prdata = {16'd0, echo_value_q};
			default:            prdata = 32'd0;
		endcase
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_slave_id_q      <= 8'd1;
			expected_function_code_q <= 8'd3;
			register_count_q         <= 6'd1;
			frame_length_q           <= 7'd5;
			echo_address_q           <= 16'd0;
			echo_value_q             <= 16'd0;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_EXPECTED_SLAVE: expected_slave_id_q      <= pwdata[7:0];
				REG_EXPECTED_FC:    expected_function_code_q <= pwdata[7:0];
				REG_REGISTER_COUNT: register_count_q         <= pwdata[5:0];
				REG_FRAME_LENGTH:   frame_length_q           <= pwdata[6:0];
				REG_ECHO_ADDRESS:   echo_address_q           <= pwdata[15:0];
				REG_ECHO_VALUE:     echo_value_q             <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// byte position and frame start
	always_comb begin
		b        = rx_item.rx_byte;
		pos      = rx_item.frame_start ? 8'd0 : byte_position_q;
		open_eff = rx_item.frame_start | frame_open_q;
		crc_eff  = rx_item.frame_start ? CRC_INIT : crc_accumulator_q;
		echo_eff = rx_item.frame_start | echo_matches_q;
		end_pos  = {1'b0, frame_length_q} + 8'd1;
		in_frame = open_eff && (pos <= end_pos);
		at_end   = in_frame && (pos == end_pos);
	end

	// header fields as they stand after this byte
	always_comb begin
		sid_n  = (pos == 8'd0) ? b : received_slave_id_q;
		fc_n   = (pos == 8'd1) ? b : received_function_q;
		bc_n   = (pos == 8'd2) ? b : received_byte_count_q;
		echo_n = echo_eff;
		if (pos == 8'd2 && b != echo_address_q[15:8]) echo_n = 1'b0;
		if (pos == 8'd3 && b != echo_address_q[7:0])  echo_n = 1'b0;
		if (pos == 8'd4 && b != echo_value_q[15:8])   echo_n = 1'b0;
		if (pos == 8'd5 && b != echo_value_q[7:0])    echo_n = 1'b0;
	end

	// register word write address
	assign pos_m4   = pos - 8'd4;
	assign word_idx = pos_m4[7:1];
	assign mem_we   = rx_take && in_frame && (pos >= 8'd4) && !pos[0]
		&& (word_idx < 7'(MAX_REGISTERS));

	// end of frame checks
	always_comb begin
		crc_ok     = (crc_accumulator_q[7:0] == received_crc_low_q)
			&& (crc_accumulator_q[15:8] == b);
		emit_n     = (register_count_q > 6'(EMIT_LIMIT)) ? 6'(EMIT_LIMIT)
			: register_count_q;
		fin_status = STATUS_OK;
		fin_regs   = 1'b0;
		if (sid_n != expected_slave_id_q) begin
			fin_status = STATUS_ID_MISMATCH;
		end else if (!crc_ok) begin
			fin_status = STATUS_CRC_ERROR;
		end else if ((fc_n & FC_EXCEPTION_BIT) != 8'd0) begin
			fin_status = STATUS_EXCEPTION;
		end else if (fc_n != expected_function_code_q) begin
			fin_status = STATUS_FC_MISMATCH;
		end else if (fc_n == FC_READ_HOLDING || fc_n == FC_READ_INPUT) begin
			if ({1'b0, register_count_q, 1'b0} != bc_n) begin
				fin_status = STATUS_BAD_COUNT;
			end else begin
				fin_regs = (emit_n != 6'd0);
			end
		end else if (fc_n == FC_WRITE_COILS || fc_n == FC_WRITE_REGS) begin
			if (!echo_n || frame_length_q < 7'd4) fin_status = STATUS_BAD_ECHO;
		end else if (fc_n == FC_COIL_STATUS) begin
			fin_regs = (emit_n != 6'd0);
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q       <= 8'd0;
			crc_accumulator_q     <= CRC_INIT;
			received_slave_id_q   <= 8'd0;
			received_function_q   <= 8'd0;
			received_byte_count_q <= 8'd0;
			received_crc_low_q    <= 8'd0;
			echo_matches_q        <= 1'b1;
			high_byte_hold_q      <= 8'd0;
			frame_open_q          <= 1'b1;
		end else if (rx_take && open_eff) begin
			if (!in_frame) begin
				// frame length lowered below the position
				byte_position_q   <= pos;
				crc_accumulator_q <= crc_eff;
				echo_matches_q    <= echo_eff;
				frame_open_q      <= 1'b0;
			end else begin
				byte_position_q       <= pos + 8'd1;
				received_slave_id_q   <= sid_n;
				received_function_q   <= fc_n;
				received_byte_count_q <= bc_n;
				echo_matches_q        <= echo_n;
				frame_open_q          <= !at_end;
				if (pos >= 8'd3 && pos[0]) high_byte_hold_q <= b;
				if (pos < {1'b0, frame_length_q}) begin
					crc_accumulator_q <= crc16_byte(crc_eff, b);
				end else begin
					crc_accumulator_q <= crc_eff;
					if (pos == {1'b0, frame_length_q}) received_crc_low_q <= b;
				end
			end
		end
	end

	// register memory: one write port, one registered read port
	assign mem_re = (seq_q == SEQ_READ);

	always_ff @(posedge clk) begin
		if (mem_we) register_store[AW'(word_idx)] <= {high_byte_hold_q, b};
		if (mem_re) rd_data_q <= register_store[AW'(reg_idx_q)];
	end

	// result sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SEQ_RUN;
			reg_idx_q   <= 5'd0;
			res_valid_q <= 1'b0;
			res_item_q  <= '0;
		end else begin
			case (seq_q)
				SEQ_RUN: begin
					if (rx_take && at_end) begin
						if (fin_regs) begin
							// slot is free whenever a byte is taken
							res_valid_q <= 1'b0;
							reg_idx_q   <= 5'd0;
							seq_q       <= SEQ_READ;
						end else begin
							res_valid_q                <= 1'b1;
							res_item_q.status         <= fin_status;
							res_item_q.exception_code <=
								(fin_status == STATUS_EXCEPTION) ? bc_n : 8'd0;
							res_item_q.has_register   <= 1'b0;
							res_item_q.register_index <= 5'd0;
							res_item_q.register_value <= 16'd0;
							res_item_q.last           <= 1'b1;
						end
					end else if (slot_free) begin
						res_valid_q <= 1'b0;
					end
				end
				SEQ_READ: begin
					if (slot_free) res_valid_q <= 1'b0;
					seq_q <= SEQ_LOAD;
				end
				SEQ_LOAD: begin
					if (slot_free) begin
						res_valid_q                <= 1'b1;
						res_item_q.status         <= STATUS_OK;
						res_item_q.exception_code <= 8'd0;
						res_item_q.has_register   <= 1'b1;
						res_item_q.register_index <= reg_idx_q;
						res_item_q.register_value <= rd_data_q;
						if ({1'b0, reg_idx_q} + 6'd1 == emit_n) begin
							res_item_q.last <= 1'b1;
							seq_q           <= SEQ_RUN;
						end else begin
							res_item_q.last <= 1'b0;
							reg_idx_q       <= reg_idx_q + 5'd1;
							seq_q           <= SEQ_READ;
						end
					end
				end
				default: seq_q <= SEQ_RUN;
			endcase
		end
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Modbus RTU response checker
// Feeds response frames one byte item at a time, from a directed set and then
// from random configurations. A scoreboard predicts each status or register
// result from the accepted bytes and compares it with what the block emits.
// ----------------------------------------------------------------------------
module tb_top;
	import mbrc_pkg::*;

	localparam int MAX_REGS       = 32;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_ITEMS   = 48;

	// function codes outside the standard set
	localparam logic [7:0] FC_NONE        = 8'h00;
	localparam logic [7:0] FC_DIAGNOSTICS = 8'h08;
	localparam logic [7:0] FC_ALL_ONES    = 8'hFF;

	// reply scoreboard: frame decoder, expected results and checks
	class reply_scoreboard;
		logic [7:0]     want_slave;
		logic [7:0]     want_fc;
		logic [5:0]     want_count;
		logic [6:0]     frame_len;
		logic [15:0]    want_echo_addr;
		logic [15:0]    want_echo_value;
		int             position;
		logic [15:0]    crc;
		logic [7:0]     got_slave;
		logic [7:0]     got_fc;
		logic [7:0]     got_count;
		logic [7:0]     got_crc_low;
		logic [7:0]     hold_high;
		bit             echo_ok;
		bit             frame_open;
		logic [15:0]    reg_words [MAX_REGS];
		mbrc_res_item_t expected_results[$];
		int             errors;
		int             frame_bytes;
		int             predicted;

		function new();
			want_slave      = 8'd1;
			want_fc         = FC_READ_HOLDING;
			want_count      = 6'd1;
			frame_len       = 7'd5;
			want_echo_addr  = '0;
			want_echo_value = '0;
			got_slave       = '0;
			got_fc          = '0;
			got_count       = '0;
			got_crc_low     = '0;
			hold_high       = '0;
			position        = 0;
			crc             = CRC_INIT;
			echo_ok         = 1'b1;
			frame_open      = 1'b1;
			errors          = 0;
			frame_bytes     = 0;
			predicted       = 0;
			foreach (reg_words[i]) reg_words[i] = '0;
		endfunction

		// reflected crc-16, one byte
		static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			c = c ^ {8'h00, b};
			for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			return c;
		endfunction

		function void set_field(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_EXPECTED_SLAVE: want_slave = v[7:0];
				REG_EXPECTED_FC:    want_fc = v[7:0];
				REG_REGISTER_COUNT: want_count = v[5:0];
				REG_FRAME_LENGTH:   frame_len = v[6:0];
				REG_ECHO_ADDRESS:   want_echo_addr = v[15:0];
				REG_ECHO_VALUE:     want_echo_value = v[15:0];
				default: ;
			endcase
		endfunction

		function void post(logic [2:0] st, logic [7:0] exc, bit has, logic [4:0] idx,
				logic [15:0] val, bit last_flag);
			mbrc_res_item_t r;
			r.status         = st;
			r.exception_code = exc;
			r.has_register   = has;
			r.register_index = idx;
			r.register_value = val;
			r.last           = last_flag;
			expected_results.push_back(r);
			predicted++;
		endfunction

		// one result per requested register, or a bare ok when none
		function void emit_words();
			int n;
			n = want_count;
			if (n > MAX_REGS) n = MAX_REGS;
			if (n == 0) begin
				post(STATUS_OK, 8'h00, 1'b0, 5'd0, 16'h0000, 1'b1);
			end else begin
				for (int k = 0; k < n; k++)
					post(STATUS_OK, 8'h00, 1'b1, 5'(k), reg_words[k], k == n - 1);
			end
		endfunction

		// checks in priority order once the crc high byte is in
		function void close_frame(logic [7:0] crc_high);
			if (got_slave != want_slave) begin
				post(STATUS_ID_MISMATCH, 8'h00, 1'b0, 5'd0, 16'h0000, 1'b1);
			end else if (crc != {crc_high, got_crc_low}) begin
				post(STATUS_CRC_ERROR, 8'h00, 1'b0, 5'd0, 16'h0000, 1'b1);
			end else if ((got_fc & FC_EXCEPTION_BIT) != 8'h00) begin
				post(STATUS_EXCEPTION, got_count, 1'b0, 5'd0, 16'h0000, 1'b1);
			end else if (got_fc != want_fc) begin
				post(STATUS_FC_MISMATCH, 8'h00, 1'b0, 5'd0, 16'h0000, 1'b1);
			end else if (got_fc == FC_READ_HOLDING || got_fc == FC_READ_INPUT) begin
				if (int'(want_count) * 2 != int'(got_count))
					post(STATUS_BAD_COUNT, 8'h00, 1'b0, 5'd0, 16'h0000, 1'b1);
				else
					emit_words();
			end else if (got_fc == FC_WRITE_COILS || got_fc == FC_WRITE_REGS) begin
				post((echo_ok && frame_len >= 7'd4) ? STATUS_OK : STATUS_BAD_ECHO,
					8'h00, 1'b0, 5'd0, 16'h0000, 1'b1);
			end else if (got_fc == FC_COIL_STATUS) begin
				emit_words();
			end else begin
				post(STATUS_OK, 8'h00, 1'b0, 5'd0, 16'h0000, 1'b1);
			end
		endfunction

		// note an accepted byte item
		function void take_byte(mbrc_rx_item_t it);
			logic [7:0] b;
			int         last_pos;
			int         w;
			b = it.rx_byte;
			if (it.frame_start) begin
				position   = 0;
				crc        = CRC_INIT;
				echo_ok    = 1'b1;
				frame_open = 1'b1;
			end
			if (!frame_open) return;
			last_pos = int'(frame_len) + 1;
			// frame length dropped below the current position
			if (position > last_pos) begin
				frame_open = 1'b0;
				return;
			end
			frame_bytes++;
			// header bytes at fixed positions
			if (position == 0) got_slave = b;
			if (position == 1) got_fc = b;
			if (position == 2) got_count = b;
			// write echo
			if (position == 2 && b != want_echo_addr[15:8]) echo_ok = 1'b0;
			if (position == 3 && b != want_echo_addr[7:0]) echo_ok = 1'b0;
			if (position == 4 && b != want_echo_value[15:8]) echo_ok = 1'b0;
			if (position == 5 && b != want_echo_value[7:0]) echo_ok = 1'b0;
			// register words, high byte first
			if (position >= 3) begin
				if (position % 2 == 1) begin
					hold_high = b;
				end else begin
					w = (position - 4) / 2;
					if (w < MAX_REGS) reg_words[w] = {hold_high, b};
				end
			end
			if (position < int'(frame_len)) crc = crc_next(crc, b);
			else if (position == int'(frame_len)) got_crc_low = b;
			position++;
			if (position - 1 == last_pos) begin
				frame_open = 1'b0;
				close_frame(b);
			end
		endfunction

		// compare an accepted result with the oldest expectation
		function void check_result(mbrc_res_item_t got);
			mbrc_res_item_t want;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result st %0d exc %h has %0b idx %0d val %h last %0b",
						$realtime, got.status, got.exception_code, got.has_register,
						got.register_index, got.register_value, got.last);
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status || got.exception_code !== want.exception_code ||
					got.has_register !== want.has_register ||
					got.register_index !== want.register_index ||
					got.register_value !== want.register_value || got.last !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected st %0d exc %h has %0b idx %0d val %h last %0b",
						want.status, want.exception_code, want.has_register,
						want.register_index, want.register_value, want.last);
					$display("  actual   st %0d exc %h has %0b idx %0d val %h last %0b",
						got.status, got.exception_code, got.has_register,
						got.register_index, got.register_value, got.last);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   rx_valid = 1'b0;
	logic                   rx_stall;
	mbrc_rx_item_t          rx_item = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	mbrc_res_item_t         res_item;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [REG_ADDR_W-1:0]  paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	bit                     calm = 1'b0;
	int                     cycle_count;
	logic [7:0]             reply_bytes[$];
	reply_scoreboard        sb;

	modbus_rtu_response_checker_unit #(
		.MAX_REGISTERS(MAX_REGS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_item   (rx_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls at random
	always @(posedge clk) begin
		res_stall <= !calm && ($urandom_range(0, 99) < 29);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_result(res_item);
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// data byte, extremes weighted up
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// present one byte item and wait for it to be taken
	task automatic send_byte(logic [7:0] b, bit first);
		mbrc_rx_item_t it;
		it.rx_byte     = b;
		it.frame_start = first;
		if (!calm && $urandom_range(0, 99) < 29) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		rx_item  <= it;
		rx_valid <= 1'b1;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		sb.take_byte(it);
	endtask

	// first cut bytes of the built reply, then trailing noise
	task automatic send_reply(int cut, int junk);
		for (int i = 0; i < cut; i++) send_byte(reply_bytes[i], i == 0);
		repeat (junk) send_byte(pick_byte(), 1'b0);
	endtask

	// reply of the configured length with crc appended low byte first
	task automatic build_reply(logic [7:0] slave, logic [7:0] fc, logic [7:0] third,
			int spoil, bit crc_good);
		logic [15:0] c;
		logic [7:0]  v;
		bit          echo_reply;
		c = CRC_INIT;
		echo_reply = (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS);
		reply_bytes = {};
		for (int p = 0; p < int'(sb.frame_len); p++) begin
			v = pick_byte();
			if (p == 0) v = slave;
			else if (p == 1) v = fc;
			else if (p == 2) v = third;
			else if (echo_reply && p == 3) v = sb.want_echo_addr[7:0];
			else if (echo_reply && p == 4) v = sb.want_echo_value[15:8];
			else if (echo_reply && p == 5) v = sb.want_echo_value[7:0];
			if (p == spoil) v = v ^ 8'($urandom_range(1, 255));
			reply_bytes.push_back(v);
			c = reply_scoreboard::crc_next(c, v);
		end
		if (!crc_good) c = c ^ (16'h0001 << $urandom_range(0, 15));
		reply_bytes.push_back(c[7:0]);
		reply_bytes.push_back(c[15:8]);
	endtask

	// wait until every expected result is out
	task automatic wait_idle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb setup and access; psel stays up for back-to-back writes
	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_field(idx, value);
	endtask

	task automatic program_link(logic [7:0] slave, logic [7:0] fc, int count, int len,
			logic [15:0] echo_addr, logic [15:0] echo_val);
		wait_idle();
		reg_write(REG_EXPECTED_SLAVE, 32'(slave));
		reg_write(REG_EXPECTED_FC, 32'(fc));
		reg_write(REG_REGISTER_COUNT, 32'(count));
		reg_write(REG_FRAME_LENGTH, 32'(len));
		reg_write(REG_ECHO_ADDRESS, 32'(echo_addr));
		reg_write(REG_ECHO_VALUE, 32'(echo_val));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random setting; frame length mostly fits the function
	task automatic random_link();
		logic [7:0] slave;
		logic [7:0] fc;
		int         count;
		int         len;
		case ($urandom_range(0, 7))
			0: slave = 8'd0;
			1: slave = 8'd247;
			default: slave = 8'($urandom_range(0, 247));
		endcase
		case ($urandom_range(0, 9))
			0: fc = FC_COIL_STATUS;
			1, 2, 8: fc = FC_READ_HOLDING;
			3, 9: fc = FC_READ_INPUT;
			4: fc = FC_WRITE_COILS;
			5: fc = FC_WRITE_REGS;
			6: fc = 8'($urandom_range(0, 255));
			default: fc = $urandom_range(0, 1) ? FC_NONE : FC_ALL_ONES;
		endcase
		count = ($urandom_range(0, 9) == 0) ? MAX_REGS : $urandom_range(0, 4);
		if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS)
			len = 6;
		else if (fc == FC_COIL_STATUS || fc == FC_READ_HOLDING || fc == FC_READ_INPUT)
			len = 3 + 2 * count;
		else
			len = $urandom_range(0, 8);
		if ($urandom_range(0, 5) == 0) len = $urandom_range(0, 67);
		program_link(slave, fc, count, len, pick_word(), pick_word());
	endtask

	// mostly well-formed replies, the rest damaged or cut short
	task automatic random_reply();
		logic [7:0] slave;
		logic [7:0] fc;
		logic [7:0] third;
		int         spoil;
		int         cut;
		int         junk;
		int         k;
		bit         crc_good;
		slave    = sb.want_slave;
		fc       = sb.want_fc;
		spoil    = -1;
		crc_good = 1'b1;
		junk     = 0;
		if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) third = 8'(2 * int'(sb.want_count));
		else if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) third = sb.want_echo_addr[15:8];
		else third = pick_byte();
		k = $urandom_range(0, 99);
		if (k >= 60 && k < 67) begin
			slave = slave + 8'($urandom_range(1, 255));
		end else if (k >= 67 && k < 74) begin
			crc_good = 1'b0;
		end else if (k >= 74 && k < 81) begin
			fc    = fc | FC_EXCEPTION_BIT;
			third = pick_byte();
		end else if (k >= 81 && k < 87) begin
			fc = fc + 8'($urandom_range(1, 255));
		end else if (k >= 87 && k < 90) begin
			third = third + 8'($urandom_range(1, 255));
		end else if (k >= 90 && k < 93) begin
			spoil = $urandom_range(2, 5);
		end
		build_reply(slave, fc, third, spoil, crc_good);
		cut = reply_bytes.size();
		if (k >= 93 && cut > 1) cut = $urandom_range(1, cut - 1);
		if ($urandom_range(0, 3) == 0) junk = $urandom_range(1, 3);
		send_reply(cut, junk);
	endtask

	// stimulus
	initial begin
		int item_mark;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// longest frame fills every register word, run without gaps
		calm = 1'b1;
		program_link(8'd1, FC_READ_HOLDING, MAX_REGS, 67, 16'h0000, 16'h0000);
		build_reply(8'd1, FC_READ_HOLDING, 8'd64, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);
		wait_idle();
		calm = 1'b0;

		// zero registers requested, wrong slave, broken crc
		program_link(8'd247, FC_READ_INPUT, 0, 3, 16'hFFFF, 16'hFFFF);
		build_reply(8'd247, FC_READ_INPUT, 8'd0, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);
		build_reply(8'd0, FC_READ_INPUT, 8'd0, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);
		build_reply(8'd247, FC_READ_INPUT, 8'd0, -1, 1'b0);
		send_reply(reply_bytes.size(), 0);

		// two-word read, bad byte count, wrong function, exception reply
		program_link(8'd0, FC_READ_HOLDING, 2, 7, 16'h0000, 16'h0000);
		build_reply(8'd0, FC_READ_HOLDING, 8'd4, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);
		build_reply(8'd0, FC_READ_HOLDING, 8'd3, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);
		build_reply(8'd0, FC_READ_INPUT, 8'd4, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);
		build_reply(8'd0, FC_READ_HOLDING | FC_EXCEPTION_BIT, 8'h02, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);

		// write echo intact, then damaged
		program_link(8'd5, FC_WRITE_REGS, 0, 6, 16'hFFFF, 16'h0000);
		build_reply(8'd5, FC_WRITE_REGS, 8'hFF, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);
		build_reply(8'd5, FC_WRITE_REGS, 8'hFF, 4, 1'b1);
		send_reply(reply_bytes.size(), 0);

		// write reply too short to hold the echo
		program_link(8'd5, FC_WRITE_COILS, 0, 3, 16'h12A5, 16'h5A34);
		build_reply(8'd5, FC_WRITE_COILS, 8'h12, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);

		// coil read hands out stored words
		program_link(8'd9, FC_COIL_STATUS, 3, 4, 16'h0000, 16'h0000);
		build_reply(8'd9, FC_COIL_STATUS, 8'd1, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);

		// crc bytes only
		program_link(8'd9, FC_DIAGNOSTICS, 1, 0, 16'h0000, 16'h0000);
		build_reply(8'd9, FC_DIAGNOSTICS, 8'd0, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);

		// other function codes pass with no registers
		program_link(8'd9, FC_DIAGNOSTICS, 1, 4, 16'h0000, 16'h0000);
		build_reply(8'd9, FC_DIAGNOSTICS, pick_byte(), -1, 1'b1);
		send_reply(reply_bytes.size(), 0);
		program_link(8'd9, FC_NONE, 1, 4, 16'h0000, 16'h0000);
		build_reply(8'd9, FC_NONE, pick_byte(), -1, 1'b1);
		send_reply(reply_bytes.size(), 0);

		// all-ones code carries the exception bit
		program_link(8'd9, FC_ALL_ONES, 1, 4, 16'h0000, 16'h0000);
		build_reply(8'd9, FC_ALL_ONES, 8'h0B, -1, 1'b1);
		send_reply(reply_bytes.size(), 0);

		// restart mid-frame, then noise after the end
		program_link(8'd3, FC_READ_HOLDING, 1, 5, 16'h0000, 16'h0000);
		build_reply(8'd3, FC_READ_HOLDING, 8'd2, -1, 1'b1);
		send_reply(3, 0);
		send_reply(reply_bytes.size(), 3);

		// random settings, a few replies each
		item_mark = sb.frame_bytes;
		while (sb.frame_bytes - item_mark < RANDOM_ITEMS) begin
			random_link();
			repeat (3) random_reply();
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d result errors, %0d results never arrived", sb.errors,
				sb.expected_results.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/mbrc_pkg.sv
rtl/core/modbus_rtu_response_checker_unit.sv
test/tb_top.sv
